// File: src/hds_pkg.sv
// ----------------------------------------------------------------------------
// Haversine distance and speed: shared package
// Number formats, turn constants, the work item passed from the front end to
// the arithmetic back end, and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package hds_pkg;

    localparam int CORDIC_ITERATIONS = 30;
    // Q2.30 datapath width with headroom for the CORDIC gain.
    localparam int CW = 34;
    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);

    localparam logic [32:0] DEG_TO_RAD_K = 33'd8048910509;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] TURN = 34'sd3600000000;
    localparam logic signed [33:0] HALF_TURN = 34'sd1800000000;
    localparam logic signed [33:0] QUARTER_TURN = 34'sd900000000;
    localparam logic [29:0] RADIUS_RESET_X100 = 30'd637100000;
    localparam logic [29:0] RADIUS_SCALE = 30'd100;
    localparam logic [15:0] SPEED_SCALE = 16'd36000;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    typedef struct packed {
        logic signed [CW-1:0] z_dlat;
        logic signed [CW-1:0] z_dlon;
        logic signed [CW-1:0] z_lat_a;
        logic signed [CW-1:0] z_lat_b;
        logic                 neg_a;
        logic                 neg_b;
        logic [31:0]          elapsed_ms;
    } hds_work_t;

    // Arctangent of 2^-i in Q2.30, truncated.
    function automatic logic signed [CW-1:0] atan_q30(input int i);
        logic signed [CW-1:0] r;
        case (i)
            0:  r = 34'sd843314856;
            1:  r = 34'sd497837829;
            2:  r = 34'sd263043836;
            3:  r = 34'sd133525158;
            4:  r = 34'sd67021686;
            5:  r = 34'sd33543515;
            6:  r = 34'sd16775850;
            7:  r = 34'sd8388437;
            8:  r = 34'sd4194282;
            9:  r = 34'sd2097149;
            10: r = 34'sd1048575;
            default:
            begin
                if (i <= 30)
                begin
                    r = CW'((64'sd1 <<< (30 - i)) - 64'sd1);
                end
                else
                begin
                    r = '0;
                end
            end
        endcase
        return r;
    endfunction

endpackage

// File: src/hds_in_if.sv
// ----------------------------------------------------------------------------
// Track point channel
// Two positions and the elapsed time between them, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hds_in_if;
    logic               valid;
    logic               ready;
    logic signed [30:0] lat_a;
    logic signed [31:0] lon_a;
    logic signed [30:0] lat_b;
    logic signed [31:0] lon_b;
    logic [31:0]        elapsed_ms;

    modport source (output valid, lat_a, lon_a, lat_b, lon_b, elapsed_ms, input ready);
    modport sink (input valid, lat_a, lon_a, lat_b, lon_b, elapsed_ms, output ready);
endinterface

// File: src/hds_out_if.sv
// ----------------------------------------------------------------------------
// Distance and speed channel
// One result per track point, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hds_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] distance_cm;
    logic [31:0] speed_m_per_h;
    logic        speed_invalid;
    logic        speed_saturated;

    modport source (output valid, distance_cm, speed_m_per_h, speed_invalid,
                    speed_saturated, input ready);
    modport sink (input valid, distance_cm, speed_m_per_h, speed_invalid,
                  speed_saturated, output ready);
endinterface

// File: src/hds_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts track points, reduces angles into one turn, folds latitudes into
// the cosine range and converts all four angles to Q2.30 radians.
// ----------------------------------------------------------------------------
module hds_front (
    input  logic              clk,
    input  logic              rst_n,
    hds_in_if.sink            track,
    output logic              push,
    output hds_pkg::hds_work_t work,
    input  logic              full
);

    localparam int CW_Z = hds_pkg::CW;

    logic adv;

    logic        f1_valid_reg;
    logic [30:0] f1_mag_reg [4];
    logic [3:0]  f1_neg_reg;
    logic        f1_cneg_a_reg;
    logic        f1_cneg_b_reg;
    logic [31:0] f1_t_reg;

    logic        f2_valid_reg;
    logic [63:0] f2_prod_reg [4];
    logic [3:0]  f2_neg_reg;
    logic        f2_cneg_a_reg;
    logic        f2_cneg_b_reg;
    logic [31:0] f2_t_reg;

    logic signed [33:0] d_lat;
    logic signed [33:0] d_lon;
    logic signed [33:0] ang [4];
    logic signed [33:0] lat_a_x;
    logic signed [33:0] lat_b_x;
    logic signed [CW_Z-1:0] rad [4];

    function automatic logic signed [33:0] wrap_turn(input logic signed [33:0] v);
        logic signed [33:0] r;
        if (v >= hds_pkg::HALF_TURN)
        begin
            r = v - hds_pkg::TURN;
        end
        else if (v < -hds_pkg::HALF_TURN)
        begin
            r = v + hds_pkg::TURN;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic signed [33:0] fold_lat(input logic signed [33:0] v);
        logic signed [33:0] r;
        if (v > hds_pkg::QUARTER_TURN)
        begin
            r = hds_pkg::HALF_TURN - v;
        end
        else if (v < -hds_pkg::QUARTER_TURN)
        begin
            r = -hds_pkg::HALF_TURN - v;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [30:0] mag31(input logic signed [33:0] v);
        logic [33:0] m;
        m = v[33] ? 34'(-v) : 34'(v);
        return m[30:0];
    endfunction

    assign adv = !f2_valid_reg || !full;
    assign track.ready = adv;
    assign push = f2_valid_reg && !full;

    // Latitudes are 31 bits, so they never leave the first turn.
    always_comb
    begin
        lat_a_x = 34'(track.lat_a);
        lat_b_x = 34'(track.lat_b);
        d_lat = lat_b_x - lat_a_x;
        d_lon = 34'(track.lon_b) - 34'(track.lon_a);
        ang[0] = wrap_turn(d_lat);
        ang[1] = wrap_turn(d_lon);
        ang[2] = fold_lat(lat_a_x);
        ang[3] = fold_lat(lat_b_x);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_valid_reg <= track.valid;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                f1_mag_reg[k] <= mag31(ang[k]);
                f1_neg_reg[k] <= ang[k][33];
                f2_prod_reg[k] <= 64'(f1_mag_reg[k]) * 64'(hds_pkg::DEG_TO_RAD_K);
            end
            f1_cneg_a_reg <= (ang[2] != lat_a_x);
            f1_cneg_b_reg <= (ang[3] != lat_b_x);
            f1_t_reg <= track.elapsed_ms;
            f2_neg_reg <= f1_neg_reg;
            f2_cneg_a_reg <= f1_cneg_a_reg;
            f2_cneg_b_reg <= f1_cneg_b_reg;
            f2_t_reg <= f1_t_reg;
        end
    end

    // Half angles for the two sines take one more bit of right shift.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            logic [64:0] rnd;
            logic [31:0] val;
            if (k < 2)
            begin
                rnd = {1'b0, f2_prod_reg[k]} + (65'd1 << 32);
                val = rnd[64:33];
            end
            else
            begin
                rnd = {1'b0, f2_prod_reg[k]} + (65'd1 << 31);
                val = rnd[63:32];
            end
            rad[k] = f2_neg_reg[k] ? -CW_Z'(val) : CW_Z'(val);
        end
    end

    always_comb
    begin
        work.z_dlat = rad[0];
        work.z_dlon = rad[1];
        work.z_lat_a = rad[2];
        work.z_lat_b = rad[3];
        work.neg_a = f2_cneg_a_reg;
        work.neg_b = f2_cneg_b_reg;
        work.elapsed_ms = f2_t_reg;
    end

endmodule

// File: src/hds_fifo.sv
// ----------------------------------------------------------------------------
// Work queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module hds_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hds_pkg::hds_work_t wdata,
    output logic               full,
    input  logic               pop,
    output hds_pkg::hds_work_t rdata,
    output logic               empty
);

    localparam int AW = hds_pkg::FIFO_AW;

    hds_pkg::hds_work_t mem_reg [hds_pkg::FIFO_DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW:0]   count_reg;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(hds_pkg::FIFO_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign full = (count_reg == (AW + 1)'(hds_pkg::FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (AW + 1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (AW + 1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: src/hds_cordic_rot.sv
// ----------------------------------------------------------------------------
// Rotation CORDIC
// Pipelined sine and cosine of a Q2.30 angle, one iteration per stage.
// ----------------------------------------------------------------------------
module hds_cordic_rot (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [hds_pkg::CW-1:0] z_in,
    output logic signed [hds_pkg::CW-1:0] sin_out,
    output logic signed [hds_pkg::CW-1:0] cos_out
);

    localparam int NI = hds_pkg::CORDIC_ITERATIONS;
    localparam int CW = hds_pkg::CW;

    logic signed [CW-1:0] x_in [NI];
    logic signed [CW-1:0] y_in [NI];
    logic signed [CW-1:0] z_st [NI];
    logic signed [CW-1:0] x_reg [NI];
    logic signed [CW-1:0] y_reg [NI];
    logic signed [CW-1:0] z_reg [NI];

    assign x_in[0] = hds_pkg::CORDIC_GAIN;
    assign y_in[0] = '0;
    assign z_st[0] = z_in;

    for (genvar i = 0; i < NI; i++)
    begin : g_stage
        if (i > 0)
        begin : g_link
            assign x_in[i] = x_reg[i-1];
            assign y_in[i] = y_reg[i-1];
            assign z_st[i] = z_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_st[i][CW-1])
                begin
                    x_reg[i] <= x_in[i] - (y_in[i] >>> i);
                    y_reg[i] <= y_in[i] + (x_in[i] >>> i);
                    z_reg[i] <= z_st[i] - hds_pkg::atan_q30(i);
                end
                else
                begin
                    x_reg[i] <= x_in[i] + (y_in[i] >>> i);
                    y_reg[i] <= y_in[i] - (x_in[i] >>> i);
                    z_reg[i] <= z_st[i] + hds_pkg::atan_q30(i);
                end
            end
        end
    end

    assign sin_out = y_reg[NI-1];
    assign cos_out = x_reg[NI-1];

endmodule

// File: src/hds_back.sv
// ----------------------------------------------------------------------------
// Back end
// Haversine term, square roots, arctangent, distance scaling and the speed
// divider, all pipelined under one stall enable, plus the output register.
// ----------------------------------------------------------------------------
module hds_back (
    input  logic               clk,
    input  logic               rst_n,
    input  hds_pkg::hds_work_t work,
    input  logic               work_valid,
    output logic               pop,
    input  logic [29:0]        radius_x100,
    hds_out_if.source          result
);

    localparam int NI = hds_pkg::CORDIC_ITERATIONS;
    localparam int CW = hds_pkg::CW;
    localparam int SQ = hds_pkg::SQRT_STEPS;
    localparam int DV = hds_pkg::DIV_STEPS;
    localparam int LAT = NI + 4 + SQ + NI + 4 + DV;
    localparam int TL = NI + 4 + SQ + NI + 3;

    typedef struct packed {
        logic [61:0] rem;
        logic [61:0] res;
    } sq_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] nq;
        logic [31:0] t;
        logic [31:0] dist_cm;
        logic        inv;
        logic        sat;
    } qs_t;

    logic en;
    logic vld_reg [LAT];
    logic [31:0] t_reg [TL];
    logic nega_reg [NI];
    logic negb_reg [NI];

    logic signed [CW-1:0] s1;
    logic signed [CW-1:0] s2;
    logic signed [CW-1:0] ca;
    logic signed [CW-1:0] cb;
    logic signed [CW-1:0] unused_c1;
    logic signed [CW-1:0] unused_c2;
    logic signed [CW-1:0] unused_s3;
    logic signed [CW-1:0] unused_s4;

    logic [63:0] m1_p11_reg;
    logic [63:0] m1_p22_reg;
    logic [63:0] m1_pcc_reg;
    logic        m1_ccneg_reg;
    logic [33:0] m2_p1_reg;
    logic [33:0] m2_p2_reg;
    logic [33:0] m2_cc_reg;
    logic        m2_ccneg_reg;
    logic [33:0] m3_p1_reg;
    logic [63:0] m3_q_reg;
    logic        m3_qneg_reg;
    logic [30:0] m4_a_reg;

    sq_t sq1_in [SQ];
    sq_t sq2_in [SQ];
    sq_t sq1_reg [SQ];
    sq_t sq2_reg [SQ];

    logic signed [CW-1:0] vx_in [NI];
    logic signed [CW-1:0] vy_in [NI];
    logic signed [CW-1:0] vz_in [NI];
    logic signed [CW-1:0] vx_reg [NI];
    logic signed [CW-1:0] vy_reg [NI];
    logic signed [CW-1:0] vz_reg [NI];

    logic [61:0] d1_prod_reg;
    logic [31:0] d2_dist_reg;
    logic [47:0] d3_num_reg;
    logic [31:0] d3_dist_reg;

    qs_t q_in [DV+1];
    qs_t q_reg [DV+1];

    logic        out_valid_reg;
    logic [31:0] out_dist_reg;
    logic [31:0] out_speed_reg;
    logic        out_inv_reg;
    logic        out_sat_reg;

    function automatic logic [31:0] mag32(input logic signed [CW-1:0] v);
        logic [CW-1:0] m;
        m = v[CW-1] ? CW'(-v) : CW'(v);
        return m[31:0];
    endfunction

    function automatic logic [33:0] round_q30(input logic [63:0] p);
        logic [64:0] r;
        r = {1'b0, p} + (65'd1 << 29);
        return r[63:30];
    endfunction

    function automatic sq_t sq_step(input sq_t s, input logic [61:0] b);
        sq_t r;
        logic [61:0] tr;
        tr = s.res + b;
        if (s.rem >= tr)
        begin
            r.rem = s.rem - tr;
            r.res = (s.res >> 1) + b;
        end
        else
        begin
            r.rem = s.rem;
            r.res = s.res >> 1;
        end
        return r;
    endfunction

    function automatic qs_t div_step(input qs_t s);
        qs_t r;
        logic [32:0] r33;
        r = s;
        r33 = {s.rem, s.nq[31]};
        if (r33 >= {1'b0, s.t})
        begin
            r.rem = 32'(r33 - {1'b0, s.t});
            r.nq = {s.nq[30:0], 1'b1};
        end
        else
        begin
            r.rem = r33[31:0];
            r.nq = {s.nq[30:0], 1'b0};
        end
        return r;
    endfunction

    assign en = !out_valid_reg || result.ready;
    assign pop = en && work_valid;

    // Valid bits and the sidebands that ride along the arithmetic.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < LAT; j++)
            begin
                vld_reg[j] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= work_valid;
            for (int j = 1; j < LAT; j++)
            begin
                vld_reg[j] <= vld_reg[j-1];
            end
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0] <= work.elapsed_ms;
            for (int j = 1; j < TL; j++)
            begin
                t_reg[j] <= t_reg[j-1];
            end
            nega_reg[0] <= work.neg_a;
            negb_reg[0] <= work.neg_b;
            for (int j = 1; j < NI; j++)
            begin
                nega_reg[j] <= nega_reg[j-1];
                negb_reg[j] <= negb_reg[j-1];
            end
        end
    end

    hds_cordic_rot u_rot_dlat (
        .clk     (clk),
        .en      (en),
        .z_in    (work.z_dlat),
        .sin_out (s1),
        .cos_out (unused_c1)
    );

    hds_cordic_rot u_rot_dlon (
        .clk     (clk),
        .en      (en),
        .z_in    (work.z_dlon),
        .sin_out (s2),
        .cos_out (unused_c2)
    );

    hds_cordic_rot u_rot_lat_a (
        .clk     (clk),
        .en      (en),
        .z_in    (work.z_lat_a),
        .sin_out (unused_s3),
        .cos_out (ca)
    );

    hds_cordic_rot u_rot_lat_b (
        .clk     (clk),
        .en      (en),
        .z_in    (work.z_lat_b),
        .sin_out (unused_s4),
        .cos_out (cb)
    );

    // a = s1^2 + cos_a*cos_b*s2^2, products in sign and magnitude.
    always_ff @(posedge clk)
    begin
        logic [64:0] a_w;
        if (en)
        begin
            m1_p11_reg <= 64'(mag32(s1)) * 64'(mag32(s1));
            m1_p22_reg <= 64'(mag32(s2)) * 64'(mag32(s2));
            m1_pcc_reg <= 64'(mag32(ca)) * 64'(mag32(cb));
            m1_ccneg_reg <= (ca[CW-1] ^ nega_reg[NI-1]) ^ (cb[CW-1] ^ negb_reg[NI-1]);

            m2_p1_reg <= round_q30(m1_p11_reg);
            m2_p2_reg <= round_q30(m1_p22_reg);
            m2_cc_reg <= round_q30(m1_pcc_reg);
            m2_ccneg_reg <= m1_ccneg_reg;

            m3_p1_reg <= m2_p1_reg;
            m3_q_reg <= 64'(m2_cc_reg[31:0]) * 64'(m2_p2_reg[31:0]);
            m3_qneg_reg <= m2_ccneg_reg;

            if (m3_qneg_reg)
            begin
                a_w = 65'(m3_p1_reg) - 65'(round_q30(m3_q_reg));
            end
            else
            begin
                a_w = 65'(m3_p1_reg) + 65'(round_q30(m3_q_reg));
            end
            if (a_w[64])
            begin
                m4_a_reg <= '0;
            end
            else if (a_w > 65'(hds_pkg::ONE_Q30))
            begin
                m4_a_reg <= hds_pkg::ONE_Q30;
            end
            else
            begin
                m4_a_reg <= a_w[30:0];
            end
        end
    end

    // Two restoring square roots, one result bit per stage.
    assign sq1_in[0] = '{rem: 62'(m4_a_reg) << 30, res: '0};
    assign sq2_in[0] = '{rem: 62'(hds_pkg::ONE_Q30 - m4_a_reg) << 30, res: '0};

    for (genvar k = 0; k < SQ; k++)
    begin : g_sqrt
        if (k > 0)
        begin : g_link
            assign sq1_in[k] = sq1_reg[k-1];
            assign sq2_in[k] = sq2_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq1_reg[k] <= sq_step(sq1_in[k], 62'd1 << (2 * (SQ - 1 - k)));
                sq2_reg[k] <= sq_step(sq2_in[k], 62'd1 << (2 * (SQ - 1 - k)));
            end
        end
    end

    // Vectoring CORDIC for the central half angle.
    assign vx_in[0] = CW'(sq2_reg[SQ-1].res[30:0]);
    assign vy_in[0] = CW'(sq1_reg[SQ-1].res[30:0]);
    assign vz_in[0] = '0;

    for (genvar i = 0; i < NI; i++)
    begin : g_vec
        if (i > 0)
        begin : g_link
            assign vx_in[i] = vx_reg[i-1];
            assign vy_in[i] = vy_reg[i-1];
            assign vz_in[i] = vz_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!vy_in[i][CW-1])
                begin
                    vx_reg[i] <= vx_in[i] + (vy_in[i] >>> i);
                    vy_reg[i] <= vy_in[i] - (vx_in[i] >>> i);
                    vz_reg[i] <= vz_in[i] + hds_pkg::atan_q30(i);
                end
                else
                begin
                    vx_reg[i] <= vx_in[i] - (vy_in[i] >>> i);
                    vy_reg[i] <= vy_in[i] + (vx_in[i] >>> i);
                    vz_reg[i] <= vz_in[i] - hds_pkg::atan_q30(i);
                end
            end
        end
    end

    // Distance scaling and the speed numerator.
    always_ff @(posedge clk)
    begin
        logic [31:0] z2;
        logic [33:0] dw;
        if (en)
        begin
            z2 = vz_reg[NI-1][CW-1] ? 32'd0 : {vz_reg[NI-1][30:0], 1'b0};
            d1_prod_reg <= 62'(z2) * 62'(radius_x100);

            dw = round_q30({2'b00, d1_prod_reg});
            d2_dist_reg <= (dw[33:32] != 2'b00) ? 32'hFFFF_FFFF : dw[31:0];

            d3_num_reg <= 48'(d2_dist_reg) * 48'(hds_pkg::SPEED_SCALE);
            d3_dist_reg <= d2_dist_reg;
        end
    end

    // The quotient overflows 32 bits exactly when the numerator's top part
    // already reaches the divisor, so only 32 quotient bits are computed.
    always_comb
    begin
        q_in[0].t = t_reg[TL-1];
        q_in[0].rem = {16'd0, d3_num_reg[47:32]};
        q_in[0].nq = d3_num_reg[31:0];
        q_in[0].dist_cm = d3_dist_reg;
        q_in[0].inv = (t_reg[TL-1] == 32'd0);
        q_in[0].sat = (t_reg[TL-1] != 32'd0) &&
                      ({16'd0, d3_num_reg[47:32]} >= t_reg[TL-1]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg[0] <= q_in[0];
        end
    end

    for (genvar k = 1; k <= DV; k++)
    begin : g_div
        assign q_in[k] = div_step(q_reg[k-1]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k] <= q_in[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_dist_reg <= q_reg[DV].dist_cm;
            out_speed_reg <= (q_reg[DV].inv || q_reg[DV].sat) ? 32'hFFFF_FFFF
                                                              : q_reg[DV].nq;
            out_inv_reg <= q_reg[DV].inv;
            out_sat_reg <= q_reg[DV].sat;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.distance_cm = out_dist_reg;
    assign result.speed_m_per_h = out_speed_reg;
    assign result.speed_invalid = out_inv_reg;
    assign result.speed_saturated = out_sat_reg;

endmodule

// File: src/haversine_distance_speed.sv
// ----------------------------------------------------------------------------
// Haversine distance and speed
// Great-circle distance between two fixes and the mean speed between them.
// ----------------------------------------------------------------------------
// Usage: a track point enters on "track" (valid/ready) with two positions in
// 1e-7 degree and the elapsed time in ms. One transaction on "result" follows
// for each one, in order: distance in cm, speed in m/h, and the invalid and
// saturated flags. The sphere radius in metres is written through cfg_wr_en
// and cfg_wr_data while the block is idle; reset loads 6371000 m.
// Throughput: one track point per cycle while "result" is not stalled. The
// front end registers each item in stages f1 and f2 and hands it to a
// four-entry queue; the back end is a pipeline of 2*CORDIC_ITERATIONS + 71
// stages (two CORDIC chains, a 31-stage square root, a 32-stage divider) plus
// the output register.
// When the receiver stalls, the whole back end holds, the queue fills and
// then ready on "track" drops. Reset empties the pipeline and the queue.
// ----------------------------------------------------------------------------
module haversine_distance_speed (
    input  logic        clk,
    input  logic        rst_n,
    hds_in_if.sink      track,
    hds_out_if.source   result,
    input  logic        cfg_wr_en,
    input  logic [22:0] cfg_wr_data
);

    logic               fifo_push;
    logic               fifo_full;
    logic               fifo_pop;
    logic               fifo_empty;
    hds_pkg::hds_work_t front_work;
    hds_pkg::hds_work_t back_work;
    logic [29:0]        radius_x100_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_x100_reg <= hds_pkg::RADIUS_RESET_X100;
        end
        else if (cfg_wr_en)
        begin
            radius_x100_reg <= 30'(cfg_wr_data) * hds_pkg::RADIUS_SCALE;
        end
    end

    hds_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .track (track),
        .push  (fifo_push),
        .work  (front_work),
        .full  (fifo_full)
    );

    hds_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fifo_push),
        .wdata (front_work),
        .full  (fifo_full),
        .pop   (fifo_pop),
        .rdata (back_work),
        .empty (fifo_empty)
    );

    hds_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .work        (back_work),
        .work_valid  (!fifo_empty),
        .pop         (fifo_pop),
        .radius_x100 (radius_x100_reg),
        .result      (result)
    );

    // A zero time forces the speed to its maximum and never counts as overflow.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.speed_invalid |->
            result.speed_m_per_h == 32'hFFFF_FFFF && !result.speed_saturated)
        else $error("zero-time result has wrong speed or flags");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.speed_saturated |-> result.speed_m_per_h == 32'hFFFF_FFFF)
        else $error("saturated speed is not at maximum");

    // The queue is never written while full and never read while empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(fifo_push && fifo_full) && !(fifo_pop && fifo_empty))
        else $error("work queue overrun or underrun");

endmodule
